@@ hw/rtl/lvsm_pkg.sv @@
package lvsm_pkg;

  localparam int unsigned IdW = 16;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [0:0] REG_MAX_VISIBLE  = 1'b0;
  localparam logic [0:0] REG_OPS_PER_TICK = 1'b1;

  typedef struct packed {
    logic [1:0]     op;
    logic [IdW-1:0] view_id;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] item_id;
    logic           visible;
    logic           last;
    logic           overflow;
  } out_item_t;

  // Request from the sequencer to a list engine.
  typedef enum logic [2:0] {
    LC_FIND,     // search for id, report position
    LC_DROP,     // remove entry at position
    LC_INS_HEAD, // insert id at front (list not full)
    LC_APPEND,   // write id at tail
    LC_POP_TAIL, // read and remove last entry
    LC_ROT_HEAD, // move entry at position to front, writing id there
    LC_HEAD      // read entry 0, set position to 0
  } lcmd_t;

  typedef struct packed {
    logic           start;
    lcmd_t          cmd;
    logic [IdW-1:0] id;
  } lreq_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RFIND,
    S_RPOP,
    S_RMOVE,
    S_EVCHK,
    S_EVPOP,
    S_QFIND,
    S_QAPP,
    S_QMOVE,
    S_XFIND,
    S_XDROP,
    S_THEAD,
    S_TDROP,
    S_TFIND,
    S_TOUT
  } st_t;

endpackage

@@ hw/rtl/lvsm_list.sv @@
// Ordered id list held in one synchronous RAM. Commands run one entry per
// step: a search streams reads, a shift moves one entry per read/write pair.
// A new command is taken in the idle state or in the cycle that done is high.
module lvsm_list #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDB   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  lvsm_pkg::lcmd_t        cmd,
  input  logic [IDB-1:0]         id,
  output logic                   done,
  output logic                   found,
  output logic [IDB-1:0]         rd_id,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import lvsm_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  typedef enum logic [2:0] {L_IDLE, L_SRCH, L_SHDN, L_SHUP, L_POP, L_DONE} lst_t;

  logic [IDB-1:0] mem [DEPTH];
  logic [IDB-1:0] q_r;

  lst_t            st_r, st_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   i_r, i_nxt;       // read pointer
  logic [CW-1:0]   pos_r, pos_nxt;   // found position
  logic            fnd_r, fnd_nxt;
  logic            rv_r, rv_nxt;     // read in flight
  logic [CW-1:0]   ri_r, ri_nxt;     // index of read in flight
  logic [IDB-1:0]  id_r, id_nxt;
  logic [IDB-1:0]  rid_r, rid_nxt;

  logic            re, we;
  logic [AW-1:0]   ra, wa;
  logic [IDB-1:0]  wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) q_r <= mem[ra];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r) inside
      L_IDLE, L_DONE: begin
        st_nxt = L_IDLE;
        if (start) begin
          unique case (cmd) inside
            LC_FIND:                  st_nxt = L_SRCH;
            LC_DROP:                  st_nxt = L_SHDN;
            LC_INS_HEAD, LC_ROT_HEAD: st_nxt = L_SHUP;
            LC_POP_TAIL, LC_HEAD:     st_nxt = L_POP;
            default:                  st_nxt = L_DONE;
          endcase
        end
      end
      L_SRCH: begin
        if ((rv_r && q_r == id_r) || (!(i_r < cnt_r) && !rv_r)) st_nxt = L_DONE;
      end
      L_SHDN: begin
        if (!rv_r && !(i_r < cnt_r)) st_nxt = L_DONE;
      end
      L_SHUP: begin
        if (!rv_r && i_r == '0) st_nxt = L_DONE;
      end
      L_POP: st_nxt = L_DONE;
      default: st_nxt = L_IDLE;
    endcase
  end

  // datapath and RAM access
  always_comb begin
    cnt_nxt = cnt_r; i_nxt = i_r; pos_nxt = pos_r; fnd_nxt = fnd_r;
    rv_nxt = 1'b0; ri_nxt = ri_r; id_nxt = id_r; rid_nxt = rid_r;
    re = 1'b0; we = 1'b0; ra = '0; wa = '0; wd = id_r;
    unique case (st_r) inside
      L_IDLE, L_DONE: begin
        if (start) begin
          id_nxt = id; fnd_nxt = 1'b0;
          unique case (cmd)
            LC_FIND: begin
              i_nxt = '0;
            end
            LC_DROP: begin
              // shift entries above pos down by one
              i_nxt = pos_r + CW'(1);
            end
            LC_INS_HEAD: begin
              pos_nxt = cnt_r;
              i_nxt = cnt_r; cnt_nxt = cnt_r + CW'(1);
            end
            LC_ROT_HEAD: begin
              i_nxt = pos_r;
            end
            LC_APPEND: begin
              we = 1'b1; wa = AW'(cnt_r); wd = id;
              cnt_nxt = cnt_r + CW'(1);
            end
            LC_POP_TAIL: begin
              re = 1'b1; ra = AW'(cnt_r - CW'(1));
              cnt_nxt = cnt_r - CW'(1);
            end
            LC_HEAD: begin
              re = 1'b1; ra = '0; pos_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      L_SRCH: begin
        // pipelined scan: issue read i, compare data of read ri
        if (rv_r && q_r == id_r) begin
          fnd_nxt = 1'b1; pos_nxt = ri_r;
        end else if (i_r < cnt_r) begin
          re = 1'b1; ra = AW'(i_r); rv_nxt = 1'b1; ri_nxt = i_r; i_nxt = i_r + CW'(1);
        end
      end
      L_SHDN: begin
        // read i, next cycle write to i-1
        if (rv_r) begin
          we = 1'b1; wa = AW'(ri_r - CW'(1)); wd = q_r;
        end
        if (i_r < cnt_r && !rv_r) begin
          re = 1'b1; ra = AW'(i_r); rv_nxt = 1'b1; ri_nxt = i_r; i_nxt = i_r + CW'(1);
        end else if (!rv_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      L_SHUP: begin
        // read i-1, next cycle write to i; finish writing id at 0
        if (rv_r) begin
          we = 1'b1; wa = AW'(ri_r + CW'(1)); wd = q_r;
        end else if (i_r == '0) begin
          we = 1'b1; wa = '0; wd = id_r;
        end else begin
          re = 1'b1; ra = AW'(i_r - CW'(1)); rv_nxt = 1'b1;
          ri_nxt = i_r - CW'(1); i_nxt = i_r - CW'(1);
        end
      end
      L_POP: begin
        rid_nxt = q_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE; cnt_r <= '0; rv_r <= 1'b0; fnd_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; rv_r <= rv_nxt; fnd_r <= fnd_nxt;
    end
    i_r <= i_nxt; pos_r <= pos_nxt; ri_r <= ri_nxt; id_r <= id_nxt;
    rid_r <= rid_nxt;
  end

  assign done  = (st_r == L_DONE);
  assign found = fnd_r;
  assign rd_id = rid_r;
  assign count = cnt_r;
endmodule

@@ hw/rtl/lru_visible_set_manager.sv @@
// Channel | Dir | Signals                         | Item
// in      | in  | in_valid, in_ready, in_data     | op, view_id
// out     | out | out_valid, out_ready, out_data  | item_id, visible, last, overflow
// cfg     | in  | cfg_we, cfg_index, cfg_wdata    | max_visible, ops_per_tick
// One item at a time; in_ready is high only when idle. A search reads the entries held
// in turn, and a shift reads and rewrites each entry that it moves. An empty tick
// leaves the manager idle and produces no output.
// Reset is synchronous and empties both lists at once (counts go to zero).
// A stalled result holds in the output register and holds the drain with it.
module lru_visible_set_manager #(
  parameter int unsigned LIST_DEPTH    = 64,
  parameter int unsigned PENDING_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lvsm_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lvsm_pkg::out_item_t   out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [6:0]            cfg_wdata
);
  import lvsm_pkg::*;

  localparam int unsigned RCW = $clog2(LIST_DEPTH+1);
  localparam int unsigned PCW = $clog2(PENDING_DEPTH+1);

  // configuration
  logic [6:0] max_vis_r, opt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vis_r <= 7'd50; opt_r <= 7'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_VISIBLE:  max_vis_r <= cfg_wdata;
        REG_OPS_PER_TICK: opt_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // list engines
  lreq_t rq, pq;
  logic r_done, r_found, p_done, p_found;
  logic [IdW-1:0] r_rd, p_rd;
  logic [RCW-1:0] r_cnt;
  logic [PCW-1:0] p_cnt;

  lvsm_list #(.DEPTH(LIST_DEPTH), .IDB(IdW)) u_recent (
    .clk, .rst_n, .start(rq.start), .cmd(rq.cmd), .id(rq.id),
    .done(r_done), .found(r_found), .rd_id(r_rd), .count(r_cnt));

  lvsm_list #(.DEPTH(PENDING_DEPTH), .IDB(IdW)) u_pend (
    .clk, .rst_n, .start(pq.start), .cmd(pq.cmd), .id(pq.id),
    .done(p_done), .found(p_found), .rd_id(p_rd), .count(p_cnt));

  st_t            st_r, st_nxt;
  logic [IdW-1:0] id_r, id_nxt;      // id under work
  logic [IdW-1:0] ev_r, ev_nxt;      // evicted / drained id
  logic           evf_r, evf_nxt;    // eviction captured, still to queue
  logic [IdW-1:0] qid_r, qid_nxt;    // id being queued
  logic           qhead_r, qhead_nxt;// queueing at head (else tail)
  logic           newid_r, newid_nxt;// pushed id was not listed
  logic           rem_r, rem_nxt;    // remove op flow
  logic           ovf_r, ovf_nxt;
  logic [6:0]     left_r, left_nxt;  // drain budget left
  logic           ov_r, ov_nxt;
  out_item_t      od_r, od_nxt;

  logic [6:0] budget;
  logic [7:0] emax;
  logic       r_full, r_over, p_full, t_last;
  assign budget = (opt_r == 7'd0) ? 7'd1 : ((opt_r > 7'd64) ? 7'd64 : opt_r);
  assign emax   = (32'(max_vis_r) > LIST_DEPTH) ? 8'(LIST_DEPTH) : {1'b0, max_vis_r};
  assign r_full = (32'(r_cnt) >= LIST_DEPTH);
  assign r_over = (32'(r_cnt) > 32'(emax));
  assign p_full = (32'(p_cnt) >= PENDING_DEPTH);
  assign t_last = (left_r == 7'd1) || (p_cnt == '0);

  assign in_ready = (st_r == S_IDLE);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_data.op)) inside
            OP_PUSH, OP_REMOVE: st_nxt = S_RFIND;
            OP_TICK: if (p_cnt != '0) st_nxt = S_THEAD;
            default: ;
          endcase
        end
      end
      S_RFIND: begin
        if (r_done) begin
          if (rem_r) st_nxt = r_found ? S_RMOVE : S_XFIND;
          else if (!r_found && r_full) st_nxt = S_RPOP;
          else st_nxt = S_RMOVE;
        end
      end
      S_RPOP: if (r_done) st_nxt = S_RMOVE;
      S_RMOVE: begin
        if (r_done) begin
          if (rem_r) st_nxt = S_XFIND;
          else if (newid_r) st_nxt = S_QFIND;
          else st_nxt = S_EVCHK;
        end
      end
      S_EVCHK: begin
        if (evf_r) st_nxt = S_QFIND;
        else if (r_over) st_nxt = S_EVPOP;
        else st_nxt = S_IDLE;
      end
      S_EVPOP: if (r_done) st_nxt = S_EVCHK;
      S_QFIND: begin
        if (p_done) begin
          if (p_found) st_nxt = qhead_r ? S_QMOVE : S_QAPP;
          else if (p_full) st_nxt = qhead_r ? S_EVCHK : S_IDLE;
          else st_nxt = S_QMOVE;
        end
      end
      S_QAPP:  if (p_done) st_nxt = S_QMOVE;
      S_QMOVE: if (p_done) st_nxt = qhead_r ? S_EVCHK : S_IDLE;
      S_XFIND: if (p_done) st_nxt = p_found ? S_XDROP : S_IDLE;
      S_XDROP: if (p_done) st_nxt = S_IDLE;
      S_THEAD: if (p_done) st_nxt = S_TDROP;
      S_TDROP: if (p_done) st_nxt = S_TFIND;
      S_TFIND: if (r_done) st_nxt = S_TOUT;
      S_TOUT: begin
        if (!ov_r || out_ready) st_nxt = t_last ? S_IDLE : S_THEAD;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // engine requests and datapath
  always_comb begin
    id_nxt = id_r; ev_nxt = ev_r; evf_nxt = evf_r; qid_nxt = qid_r;
    qhead_nxt = qhead_r; newid_nxt = newid_r; rem_nxt = rem_r; ovf_nxt = ovf_r;
    left_nxt = left_r; od_nxt = od_r;
    ov_nxt = ov_r && !out_ready;
    rq = '{start: 1'b0, cmd: LC_FIND, id: id_r};
    pq = '{start: 1'b0, cmd: LC_FIND, id: qid_r};
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt = in_data.view_id;
          evf_nxt = 1'b0;
          unique case (op_t'(in_data.op))
            OP_PUSH: begin
              rem_nxt = 1'b0;
              rq = '{start: 1'b1, cmd: LC_FIND, id: in_data.view_id};
            end
            OP_REMOVE: begin
              rem_nxt = 1'b1;
              rq = '{start: 1'b1, cmd: LC_FIND, id: in_data.view_id};
            end
            OP_TICK: begin
              left_nxt = budget;
              if (p_cnt != '0) pq = '{start: 1'b1, cmd: LC_HEAD, id: id_r};
            end
            default: ;
          endcase
        end
      end
      S_RFIND: begin
        if (r_done) begin
          newid_nxt = !r_found;
          if (rem_r) begin
            if (r_found) rq = '{start: 1'b1, cmd: LC_DROP, id: id_r};
            else pq = '{start: 1'b1, cmd: LC_FIND, id: id_r};
          end else if (r_found) begin
            rq = '{start: 1'b1, cmd: LC_ROT_HEAD, id: id_r};
          end else if (r_full) begin
            // full: pop tail first, then insert
            rq = '{start: 1'b1, cmd: LC_POP_TAIL, id: id_r};
          end else begin
            rq = '{start: 1'b1, cmd: LC_INS_HEAD, id: id_r};
          end
        end
      end
      S_RPOP: begin
        if (r_done) begin
          ev_nxt = r_rd; evf_nxt = 1'b1;
          rq = '{start: 1'b1, cmd: LC_INS_HEAD, id: id_r};
        end
      end
      S_RMOVE: begin
        if (r_done) begin
          if (rem_r) begin
            pq = '{start: 1'b1, cmd: LC_FIND, id: id_r};
          end else if (newid_r) begin
            // new id goes to the pending head
            qid_nxt = id_r; qhead_nxt = 1'b1;
            pq = '{start: 1'b1, cmd: LC_FIND, id: id_r};
          end
        end
      end
      S_EVCHK: begin
        // at most one eviction per push, queued at the pending tail
        if (evf_r) begin
          qid_nxt = ev_r; qhead_nxt = 1'b0;
          pq = '{start: 1'b1, cmd: LC_FIND, id: ev_r};
        end else if (r_over) begin
          rq = '{start: 1'b1, cmd: LC_POP_TAIL, id: id_r};
        end
      end
      S_EVPOP: begin
        if (r_done) begin
          ev_nxt = r_rd; evf_nxt = 1'b1;
        end
      end
      S_QFIND: begin
        if (p_done) begin
          if (p_found) begin
            pq = '{start: 1'b1, cmd: qhead_r ? LC_ROT_HEAD : LC_DROP, id: qid_r};
          end else if (p_full) begin
            ovf_nxt = 1'b1;
          end else begin
            pq = '{start: 1'b1, cmd: qhead_r ? LC_INS_HEAD : LC_APPEND, id: qid_r};
          end
        end
      end
      S_QAPP: begin
        // tail requeue of a pending id: dropped, now append
        if (p_done) pq = '{start: 1'b1, cmd: LC_APPEND, id: qid_r};
      end
      S_XFIND: begin
        if (p_done && p_found) pq = '{start: 1'b1, cmd: LC_DROP, id: id_r};
      end
      S_THEAD: begin
        if (p_done) begin
          ev_nxt = p_rd;
          pq = '{start: 1'b1, cmd: LC_DROP, id: p_rd};
        end
      end
      S_TDROP: begin
        if (p_done) rq = '{start: 1'b1, cmd: LC_FIND, id: ev_r};
      end
      S_TOUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          od_nxt.item_id  = ev_r;
          od_nxt.visible  = r_found;
          od_nxt.last     = t_last;
          od_nxt.overflow = ovf_r;
          left_nxt = left_r - 7'd1;
          if (!t_last) pq = '{start: 1'b1, cmd: LC_HEAD, id: qid_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovf_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
    end
    id_r <= id_nxt; ev_r <= ev_nxt; evf_r <= evf_nxt; qid_r <= qid_nxt;
    qhead_r <= qhead_nxt; newid_r <= newid_nxt; rem_r <= rem_nxt;
    left_r <= left_nxt; od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
